// ===== src/c2t_pkg.sv =====
package c2t_pkg;

    localparam int LENGTH_BITS_DEF = 28;
    localparam int MAX_DIGITS_DEF  = 9;

    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_I  = 4'd1;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_S  = 4'd4;
    localparam logic [3:0] OP_H  = 4'd5;
    localparam logic [3:0] OP_P  = 4'd6;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;
    localparam logic [3:0] OP_B  = 4'd9;

    typedef struct packed {
        logic [3:0] code;
        logic       last;
        logic       empty;
    } t_ctrl;

    function automatic logic [7:0] op_letter(input logic [3:0] code);
        logic [7:0] ch;
        unique case (code)
            OP_M:    ch = 8'h4D;
            OP_I:    ch = 8'h49;
            OP_D:    ch = 8'h44;
            OP_N:    ch = 8'h4E;
            OP_S:    ch = 8'h53;
            OP_H:    ch = 8'h48;
            OP_P:    ch = 8'h50;
            OP_EQ:   ch = 8'h3D;
            OP_X:    ch = 8'h58;
            OP_B:    ch = 8'h42;
            default: ch = 8'h3F;
        endcase
        return ch;
    endfunction

    // largest value that fits in the given number of decimal digits
    function automatic logic [63:0] digit_limit(input int ndigits);
        logic [63:0] lim;
        lim = 64'd1;
        for (int i = 0; i < ndigits; i++) begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

endpackage

// ===== src/c2t_digit_cell.sv =====
module c2t_digit_cell #(
    parameter int LENGTH_BITS = 28,
    parameter int MAX_DIGITS  = 9,
    parameter int POS         = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [LENGTH_BITS-1:0]             i_value,
    input  logic [MAX_DIGITS-1:0][3:0]         i_digits,
    input  logic [$clog2(MAX_DIGITS+1)-1:0]    i_ndig,
    input  c2t_pkg::t_ctrl                     i_ctrl,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [LENGTH_BITS-1:0]             o_value,
    output logic [MAX_DIGITS-1:0][3:0]         o_digits,
    output logic [$clog2(MAX_DIGITS+1)-1:0]    o_ndig,
    output c2t_pkg::t_ctrl                     o_ctrl
);
    import c2t_pkg::*;

    localparam int          NDW   = $clog2(MAX_DIGITS + 1);
    localparam logic [63:0] LIMIT = digit_limit(MAX_DIGITS);

    logic                       r_valid;
    logic [LENGTH_BITS-1:0]     r_value;
    logic [MAX_DIGITS-1:0][3:0] r_digits;
    logic [NDW-1:0]             r_ndig;
    t_ctrl                      r_ctrl;

    logic [LENGTH_BITS-1:0]     w_in;
    logic [31:0]                w_x;
    logic [63:0]                w_prod;
    logic [31:0]                w_q;
    logic [31:0]                w_rem;
    logic [LENGTH_BITS-1:0]     n_value;
    logic [MAX_DIGITS-1:0][3:0] n_digits;
    logic [NDW-1:0]             n_ndig;
    logic                       w_load;

    assign w_load  = i_valid && !o_stall;
    assign o_stall = r_valid && i_stall;

    always_comb begin
        if (POS == 0 && 64'(i_value) > LIMIT) begin
            w_in = LIMIT[LENGTH_BITS-1:0];
        end else begin
            w_in = i_value;
        end
        w_x    = 32'(w_in);
        w_prod = 64'(w_x) * 64'(RECIP_10);
        w_q    = 32'(w_prod >> RECIP_SHIFT);
        w_rem  = w_x - ((w_q << 3) + (w_q << 1));
        n_value         = LENGTH_BITS'(w_q);
        n_digits        = i_digits;
        n_digits[POS]   = w_rem[3:0];
        if (POS == 0) begin
            n_ndig = NDW'(1);
        end else begin
            n_ndig = i_ndig + NDW'(w_in != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_value  <= n_value;
            r_digits <= n_digits;
            r_ndig   <= n_ndig;
            r_ctrl   <= i_ctrl;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_digits = r_digits;
    assign o_ndig   = r_ndig;
    assign o_ctrl   = r_ctrl;

endmodule

// ===== src/c2t_serializer.sv =====
module c2t_serializer #(
    parameter int MAX_DIGITS = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [MAX_DIGITS-1:0][3:0]      i_digits,
    input  logic [$clog2(MAX_DIGITS+1)-1:0] i_ndig,
    input  c2t_pkg::t_ctrl                  i_ctrl,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_out_char,
    output logic                            o_last_char
);
    import c2t_pkg::*;

    localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                       r_busy;
    logic                       r_digit_phase;
    logic [PW-1:0]              r_pos;
    logic [MAX_DIGITS-1:0][3:0] r_digits;
    t_ctrl                      r_ctrl;
    logic                       r_out_valid;
    logic [7:0]                 r_out_char;
    logic                       r_out_last;

    logic       w_advance;
    logic       w_done;
    logic       w_load;
    logic [7:0] n_char;
    logic       n_last;

    assign w_advance = r_busy && (!r_out_valid || !i_stall);
    assign w_done    = w_advance && !r_digit_phase;
    assign w_load    = i_valid && (!r_busy || w_done);
    assign o_stall   = r_busy && !w_done;

    always_comb begin
        if (r_digit_phase) begin
            n_char = CHAR_ZERO + {4'b0000, r_digits[r_pos]};
            n_last = 1'b0;
        end else if (r_ctrl.empty) begin
            n_char = CHAR_STAR;
            n_last = 1'b1;
        end else begin
            n_char = op_letter(r_ctrl.code);
            n_last = r_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_digit_phase <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_busy        <= 1'b1;
                r_digit_phase <= !i_ctrl.empty;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_advance && r_pos == '0) begin
                r_digit_phase <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_char <= n_char;
            r_out_last <= n_last;
        end
        if (w_load) begin
            r_pos    <= PW'(i_ndig - 1'b1);
            r_digits <= i_digits;
            r_ctrl   <= i_ctrl;
        end else if (w_advance && r_digit_phase && r_pos != '0) begin
            r_pos <= r_pos - 1'b1;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

// ===== src/cigar_op_to_text.sv =====
// channel | direction  | handshake         | word
// in      | to block   | i_valid / o_stall | i_op_code, i_op_length, i_last_op, i_empty_record
// out     | from block | o_valid / i_stall | o_out_char, o_last_char
//
// one word in gives one character per cycle while i_stall is low: a lone '*' for an empty
// record, else its digits and the letter (two to MAX_DIGITS+1); the output serializer sets
// that rate, the next word loads as the letter leaves
// the digit cell chain is MAX_DIGITS cells deep, one decimal digit per cell via a reciprocal
// multiply; a word passes each cell register in turn, then the serializer's registers
// synchronous active-low reset clears all valid flags; stall ripples back through the chain
module cigar_op_to_text #(
    parameter int LENGTH_BITS = c2t_pkg::LENGTH_BITS_DEF,
    parameter int MAX_DIGITS  = c2t_pkg::MAX_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [3:0]             i_op_code,
    input  logic [LENGTH_BITS-1:0] i_op_length,
    input  logic                   i_last_op,
    input  logic                   i_empty_record,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_out_char,
    output logic                   o_last_char
);
    import c2t_pkg::*;

    localparam int NDW = $clog2(MAX_DIGITS + 1);

    logic                       w_valid  [0:MAX_DIGITS];
    logic                       w_stall  [0:MAX_DIGITS];
    logic [LENGTH_BITS-1:0]     w_value  [0:MAX_DIGITS];
    logic [MAX_DIGITS-1:0][3:0] w_digits [0:MAX_DIGITS];
    logic [NDW-1:0]             w_ndig   [0:MAX_DIGITS];
    t_ctrl                      w_ctrl   [0:MAX_DIGITS];

    assign w_valid[0]  = i_valid;
    assign o_stall     = w_stall[0];
    assign w_value[0]  = i_op_length;
    assign w_digits[0] = '0;
    assign w_ndig[0]   = '0;
    assign w_ctrl[0]   = '{code: i_op_code, last: i_last_op, empty: i_empty_record};

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        c2t_digit_cell #(
            .LENGTH_BITS (LENGTH_BITS),
            .MAX_DIGITS  (MAX_DIGITS),
            .POS         (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[g]),
            .o_stall  (w_stall[g]),
            .i_value  (w_value[g]),
            .i_digits (w_digits[g]),
            .i_ndig   (w_ndig[g]),
            .i_ctrl   (w_ctrl[g]),
            .o_valid  (w_valid[g+1]),
            .i_stall  (w_stall[g+1]),
            .o_value  (w_value[g+1]),
            .o_digits (w_digits[g+1]),
            .o_ndig   (w_ndig[g+1]),
            .o_ctrl   (w_ctrl[g+1])
        );
    end

    c2t_serializer #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[MAX_DIGITS]),
        .o_stall     (w_stall[MAX_DIGITS]),
        .i_digits    (w_digits[MAX_DIGITS]),
        .i_ndig      (w_ndig[MAX_DIGITS]),
        .i_ctrl      (w_ctrl[MAX_DIGITS]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

// ===== src/c2t_checker.sv =====
module c2t_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic       o_last_char
);
    import c2t_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_last_char))
        else $error("output word changed while stalled");

    a_last_not_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char |-> (o_out_char < CHAR_ZERO || o_out_char > CHAR_NINE))
        else $error("record end marked on a digit");

    a_star_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_char == CHAR_STAR |-> o_last_char)
        else $error("empty record marker without record end");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall after reset");

endmodule

bind cigar_op_to_text c2t_checker u_chk (.*);
